>>> sv/extended_euclid_unit_top_defines.svh
// ----------------------------------------------------------------------------
// Extended Euclid unit assertion macros
// Shared property wrappers for the interface checker.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_EUCLID_UNIT_TOP_DEFINES_SVH
`define EXTENDED_EUCLID_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EEU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EEU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/eeu_pkg.sv
// ----------------------------------------------------------------------------
// Extended Euclid unit package
// Shared width default, sequencer states and control/status bundles.
// ----------------------------------------------------------------------------
package eeu_pkg;

  localparam int WIDTH_DEF = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE
  } state_t;

  // sequencer -> datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic div_init;  // seed the serial divider
    logic div_step;  // one quotient bit
    logic update;    // advance remainder/coefficient sequences
    logic finish;    // latch result fields
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic r1_zero;
    logic r1_le1;
    logic op_inv;
  } sts_t;

endpackage

>>> sv/eeu_datapath.sv
// ----------------------------------------------------------------------------
// Extended Euclid unit datapath
// Remainder and coefficient registers, restoring divider with shift-add
// quotient products, and the result registers.
// ----------------------------------------------------------------------------
module eeu_datapath #(
  parameter int WIDTH = eeu_pkg::WIDTH_DEF
) (
  input  logic               clk,
  input  eeu_pkg::ctl_t      ctl,
  output eeu_pkg::sts_t      sts,
  input  logic               op,
  input  logic [WIDTH-1:0]   opnd_a,
  input  logic [WIDTH-1:0]   opnd_b,
  output logic [WIDTH-1:0]   gcd_value,
  output logic [WIDTH:0]     coef_x,
  output logic [WIDTH:0]     coef_y,
  output logic [WIDTH-1:0]   inverse
);
  import eeu_pkg::*;

  localparam int CW = WIDTH + 1;

  logic [WIDTH-1:0] r0_r, r1_r, m_r, rem_r, quo_r;
  logic [CW-1:0]    s0_r, s1_r, t0_r, t1_r, ps_r, pt_r;
  logic             op_r;
  logic [WIDTH-1:0] gcd_r, inv_r;
  logic [CW-1:0]    cx_r, cy_r;

  logic [CW-1:0]    shifted;
  logic [CW:0]      diff;
  logic             qbit;
  logic [WIDTH-1:0] rem_nxt;
  logic [CW-1:0]    ps_nxt, pt_nxt;
  logic             s1_pos;
  logic [CW-1:0]    s1_plus_m;
  logic [WIDTH-1:0] inv_val;

  // restoring divide step: one quotient bit, MSB first
  always_comb begin
    shifted = {rem_r, quo_r[WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, r1_r};
    qbit    = ~diff[CW];
    rem_nxt = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    // Horner accumulation of q*s1 and q*t1, modulo 2^CW
    ps_nxt  = {ps_r[CW-2:0], 1'b0} + (qbit ? s1_r : '0);
    pt_nxt  = {pt_r[CW-2:0], 1'b0} + (qbit ? t1_r : '0);
  end

  // inverse: zero unless the remainder is one; a negative coefficient folds back into 1..m-1
  always_comb begin
    s1_pos    = (s1_r != '0) && !s1_r[CW-1];
    s1_plus_m = s1_r + {1'b0, m_r};
    if (r1_r != WIDTH'(1)) begin
      inv_val = '0;
    end else if (s1_pos) begin
      inv_val = s1_r[WIDTH-1:0];
    end else begin
      inv_val = s1_plus_m[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r <= op;
      r0_r <= opnd_a;
      r1_r <= opnd_b;
      m_r  <= opnd_b;
      s0_r <= CW'(1);
      s1_r <= '0;
      t0_r <= '0;
      t1_r <= CW'(1);
    end
    if (ctl.div_init) begin
      rem_r <= '0;
      quo_r <= r0_r;
      ps_r  <= '0;
      pt_r  <= '0;
    end
    if (ctl.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[WIDTH-2:0], qbit};
      ps_r  <= ps_nxt;
      pt_r  <= pt_nxt;
    end
    if (ctl.update) begin
      r0_r <= r1_r;
      r1_r <= rem_r;
      s0_r <= s1_r;
      s1_r <= s0_r - ps_r;
      t0_r <= t1_r;
      t1_r <= t0_r - pt_r;
    end
    if (ctl.finish) begin
      if (op_r) begin
        gcd_r <= '0;
        cx_r  <= '0;
        cy_r  <= '0;
        inv_r <= inv_val;
      end else begin
        gcd_r <= r0_r;
        cx_r  <= s0_r;
        cy_r  <= t0_r;
        inv_r <= '0;
      end
    end
  end

  assign sts.r1_zero = (r1_r == '0);
  assign sts.r1_le1  = (r1_r[WIDTH-1:1] == '0);
  assign sts.op_inv  = op_r;

  assign gcd_value = gcd_r;
  assign coef_x    = cx_r;
  assign coef_y    = cy_r;
  assign inverse   = inv_r;

endmodule

>>> sv/eeu_ctrl.sv
// ----------------------------------------------------------------------------
// Extended Euclid unit sequencer
// Walks load, exit check, serial divide and update steps per request.
// ----------------------------------------------------------------------------
module eeu_ctrl #(
  parameter int WIDTH = eeu_pkg::WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  eeu_pkg::sts_t sts,
  output eeu_pkg::ctl_t ctl
);
  import eeu_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             done_loop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // xgcd runs to a zero remainder, inverse stops at one or below
  assign done_loop = sts.op_inv ? sts.r1_le1 : sts.r1_zero;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (done_loop) begin
          ctl.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          ctl.div_init = 1'b1;
          cnt_nxt      = CNT_W'(WIDTH - 1);
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/extended_euclid_unit_top.sv
// ----------------------------------------------------------------------------
// Extended Euclid unit top level
// Extended gcd with Bezout coefficients, or modular inverse, per request.
// ----------------------------------------------------------------------------
// The serial divider produces one quotient bit per cycle.
// Throughput: one request in flight; busy is high until the result strobe.
// A new start is taken in the strobe cycle. out_valid is high for one cycle;
// the result outputs hold until the next request finishes.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module extended_euclid_unit_top #(
  parameter int WIDTH = eeu_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [WIDTH-1:0]    in_operand_a,
  input  logic [WIDTH-1:0]    in_operand_b,
  // result channel
  output logic                out_valid,
  output logic [WIDTH-1:0]    out_gcd_value,
  output logic signed [WIDTH:0] out_coef_x,
  output logic signed [WIDTH:0] out_coef_y,
  output logic [WIDTH-1:0]    out_inverse
);
  import eeu_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer: idle -> check -> (divide -> update -> check)*
  eeu_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  // shared divider + coefficient update; result registers hold until the
  // next request finishes
  eeu_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .sts       (sts),
    .op        (in_operation),
    .opnd_a    (in_operand_a),
    .opnd_b    (in_operand_b),
    .gcd_value (out_gcd_value),
    .coef_x    (out_coef_x),
    .coef_y    (out_coef_y),
    .inverse   (out_inverse)
  );

endmodule

>>> sv/eeu_checker.sv
// ----------------------------------------------------------------------------
// Extended Euclid unit port checker
// Watches the top-level ports for request and result sequencing.
// ----------------------------------------------------------------------------
`include "extended_euclid_unit_top_defines.svh"

module eeu_checker #(
  parameter int WIDTH = eeu_pkg::WIDTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [WIDTH-1:0]   out_gcd_value,
  input logic [WIDTH:0]     out_coef_x,
  input logic [WIDTH:0]     out_coef_y,
  input logic [WIDTH-1:0]   out_inverse
);
  import eeu_pkg::*;

  `EEU_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "request not taken")
  `EEU_ASSERT_NXT(a_strobe_once, clk, rst_n, out_valid, !out_valid, "strobe held")
  `EEU_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy, "result while busy")
  `EEU_ASSERT_IMP(a_fields_excl, clk, rst_n, out_valid,
                  out_inverse == '0 || (out_gcd_value == '0 && out_coef_x == '0 &&
                  out_coef_y == '0), "both result groups set")

endmodule

bind extended_euclid_unit_top eeu_checker #(.WIDTH(WIDTH)) u_eeu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_gcd_value (out_gcd_value),
  .out_coef_x    (out_coef_x),
  .out_coef_y    (out_coef_y),
  .out_inverse   (out_inverse)
);

>>> verif/eeu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Extended Euclid unit checker
// Watches the request and result channels and predicts each result from the
// accepted request. Compares results field by field in arrival order and
// counts mismatches.
// ----------------------------------------------------------------------------
module eeu_tb_checker #(
  parameter int W = eeu_pkg::WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         busy,
  input  logic         in_operation,
  input  logic [W-1:0] in_operand_a,
  input  logic [W-1:0] in_operand_b,
  input  logic         out_valid,
  input  logic [W-1:0] out_gcd_value,
  input  logic [W:0]   out_coef_x,
  input  logic [W:0]   out_coef_y,
  input  logic [W-1:0] out_inverse,
  output int           fail_count,
  output int           pending_count
);

  typedef struct packed {
    logic [W-1:0] gcd_value;
    logic [W:0]   coef_x;
    logic [W:0]   coef_y;
    logic [W-1:0] inverse;
  } euclid_result_t;

  euclid_result_t awaited_results[$];
  int mismatches = 0;
  int awaiting   = 0;

  assign fail_count    = mismatches;
  assign pending_count = awaiting;

  // inverse_op set: inverse of a mod b; otherwise extended gcd of a and b.
  function automatic euclid_result_t predict_euclid(logic inverse_op,
                                                    logic [W-1:0] a,
                                                    logic [W-1:0] b);
    euclid_result_t res;
    longint r0, r1, s0, s1, t0, t1, q, tmp;
    res = '0;
    r0 = longint'(a);
    r1 = longint'(b);
    s0 = 1;
    s1 = 0;
    t0 = 0;
    t1 = 1;
    if (!inverse_op) begin
      if (b == 0) begin
        res.gcd_value = a;
        res.coef_x    = (W+1)'(1);
        return res;
      end
      while (r1 != 0) begin
        q   = r0 / r1;
        tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        tmp = s0 - q * s1; s0 = s1; s1 = tmp;
        tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      res.gcd_value = r0[W-1:0];
      res.coef_x    = s0[W:0];
      res.coef_y    = t0[W:0];
    end else begin
      // stop one step early: remainder 1 means a unit, 0 means none
      while (r1 > 1) begin
        q   = r0 / r1;
        tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        tmp = s0 - q * s1; s0 = s1; s1 = tmp;
      end
      if (r1 == 1) begin
        tmp = (s1 > 0) ? s1 : s1 + longint'(b);
        res.inverse = tmp[W-1:0];
      end
    end
    return res;
  endfunction

  function automatic void check_field(string field, logic [W:0] want, logic [W:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    euclid_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("gcd_value", {1'b0, want.gcd_value}, {1'b0, out_gcd_value});
          check_field("coef_x", want.coef_x, out_coef_x);
          check_field("coef_y", want.coef_y, out_coef_y);
          check_field("inverse", {1'b0, want.inverse}, {1'b0, out_inverse});
        end
      end
      if (start && !busy)
        awaited_results.push_back(predict_euclid(in_operation, in_operand_a,
                                                 in_operand_b));
    end
    awaiting <= awaited_results.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Extended Euclid unit testbench
// Directed corner requests, then about 400 random requests with idle
// bursts, against a checker that predicts every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int W = eeu_pkg::WIDTH_DEF;

  // operation codes on in_operation
  localparam logic OP_XGCD    = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  localparam logic [W-1:0] OPND_MAX = {W{1'b1}};

  // consecutive Fibonacci numbers: the longest Euclid chain at this width
  localparam logic [W-1:0] FIB_HI = 31'd1836311903;
  localparam logic [W-1:0] FIB_LO = 31'd1134903170;

  localparam int RANDOM_REQUESTS = 400;
  localparam int CALM_TAIL       = 60;    // last requests, no idling
  localparam int DRAIN_CYCLES    = 1600;
  // ~425 requests at the slowest request time plus worst sender gap, taken ~4.5x
  localparam int CYCLE_LIMIT     = 3_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_operation;
  logic [W-1:0] in_operand_a;
  logic [W-1:0] in_operand_b;
  logic out_valid;
  logic [W-1:0] out_gcd_value;
  logic signed [W:0] out_coef_x;
  logic signed [W:0] out_coef_y;
  logic [W-1:0] out_inverse;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int xgcd_sent = 0;
  int inverse_sent = 0;

  always #5 clk = ~clk;

  extended_euclid_unit_top #(.WIDTH(W)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_valid     (out_valid),
    .out_gcd_value (out_gcd_value),
    .out_coef_x    (out_coef_x),
    .out_coef_y    (out_coef_y),
    .out_inverse   (out_inverse)
  );

  eeu_tb_checker #(.W(W)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_valid     (out_valid),
    .out_gcd_value (out_gcd_value),
    .out_coef_x    (out_coef_x),
    .out_coef_y    (out_coef_y),
    .out_inverse   (out_inverse),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Timeout guard: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one request and hold start until the block takes it.
  // start stays high on return so back-to-back requests need no idle gap;
  // the acceptance edge is the one where busy (pre-edge) was low.
  task automatic send_request(input logic op, input logic [W-1:0] a,
                              input logic [W-1:0] b);
    start        <= 1'b1;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_INVERSE) inverse_sent++;
    else xgcd_sent++;
  endtask

  // Drop start and wait until the checker holds no outstanding request.
  // The first edge lets the checker's registered count catch up with its queue.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Mix of small, near-full-scale, single-bit and full-range operands.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return W'($urandom_range(0, 16));
      1:       return OPND_MAX - W'($urandom_range(0, 16));
      2:       return W'(1) << $urandom_range(0, W - 1);
      default: return W'($urandom_range(0, OPND_MAX));
    endcase
  endfunction

  initial begin
    logic         op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] f_lo;
    logic [W-1:0] f_hi;
    logic [W-1:0] f_tmp;
    int unsigned  factor;
    int unsigned  steps;
    bit           gappy;

    // every input known from time zero, with reset asserted first
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_XGCD;
    in_operand_a = '0;
    in_operand_b = '0;
    gappy        = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corners: extended gcd ----
    send_request(OP_XGCD, '0, '0);              // both zero -> gcd 0, x 1
    send_request(OP_XGCD, 31'd12345, '0);       // second operand zero
    send_request(OP_XGCD, '0, 31'd777);         // first operand zero
    send_request(OP_XGCD, OPND_MAX, OPND_MAX);  // equal, full scale
    send_request(OP_XGCD, OPND_MAX, 31'd1);
    send_request(OP_XGCD, 31'd1, OPND_MAX);
    send_request(OP_XGCD, OPND_MAX, OPND_MAX - 1);
    send_request(OP_XGCD, FIB_HI, FIB_LO);      // longest chain
    send_request(OP_XGCD, FIB_LO, FIB_HI);      // same, swapped
    send_request(OP_XGCD, 31'h4000_0000, 31'h2000_0000);
    send_request(OP_XGCD, 31'd240, 31'd46);

    // ---- directed corners: modular inverse ----
    send_request(OP_INVERSE, 31'd3, '0);        // modulus zero -> none
    send_request(OP_INVERSE, '0, 31'd1);        // modulus one -> 1
    send_request(OP_INVERSE, OPND_MAX, 31'd1);
    send_request(OP_INVERSE, '0, 31'd5);        // zero has no inverse
    send_request(OP_INVERSE, 31'd6, 31'd9);     // shared factor -> none
    send_request(OP_INVERSE, 31'd3, 31'd7);
    send_request(OP_INVERSE, 31'd10, 31'd7);    // operand above modulus
    send_request(OP_INVERSE, OPND_MAX, OPND_MAX - 1);
    send_request(OP_INVERSE, 31'd1, OPND_MAX);
    send_request(OP_INVERSE, FIB_LO, FIB_HI);
    send_request(OP_INVERSE, OPND_MAX - 1, OPND_MAX);

    // sender holds off until everything is back
    wait_drained();

    // ---- random requests ----
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // every 50 requests, choose at random between stretches with and without idling
      if (n % 50 == 0) gappy = 1'($urandom_range(0, 1));
      if (n == RANDOM_REQUESTS / 2) wait_drained();
      if (gappy && n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end

      op = $urandom_range(0, 1) ? OP_INVERSE : OP_XGCD;
      a  = pick_operand();
      b  = pick_operand();
      case ($urandom_range(0, 7))
        0: begin
          // shared factor, so gcd > 1 and inverses mostly fail
          factor = $urandom_range(2, 3000);
          a = W'(factor * $urandom_range(0, OPND_MAX / factor));
          b = W'(factor * $urandom_range(0, OPND_MAX / factor));
        end
        1: begin
          // consecutive Fibonacci pair of random length
          f_lo  = W'(1);
          f_hi  = W'(1);
          steps = $urandom_range(1, 44);
          repeat (steps) begin
            f_tmp = f_hi + f_lo;
            f_lo  = f_hi;
            f_hi  = f_tmp;
          end
          a = $urandom_range(0, 1) ? f_hi : f_lo;
          b = (a == f_hi) ? f_lo : f_hi;
        end
        default: ;
      endcase
      send_request(op, a, b);
    end

    // ---- end of run: drain, then watch for stray strobes ----
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d extended-gcd and %0d modular-inverse requests: zero, unit,",
             xgcd_sent, inverse_sent);
    $display("full-scale, shared-factor and Fibonacci operands, with idle bursts.");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
